FILE: hdl/rounded_word_crc32_accumulator_macros.svh
// ----------------------------------------------------------------------------
// rounded word crc32 accumulator assertion macros
// shared concurrent assertion forms, clocked on aclk, held off during reset
// ----------------------------------------------------------------------------
`ifndef ROUNDED_WORD_CRC32_ACCUMULATOR_MACROS_SVH
`define ROUNDED_WORD_CRC32_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define RWC32_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rwc32 same-cycle check failed");

// next-cycle implication
`define RWC32_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rwc32 next-cycle check failed");

`endif

FILE: hdl/rwc32_pkg.sv
// ----------------------------------------------------------------------------
// rwc32_pkg
// widths, register indexes, rounding and crc helpers for the rounded word crc32 block
// ----------------------------------------------------------------------------
package rwc32_pkg;

    localparam int WORD_W = 32;
    localparam int CLR_W  = 5;
    localparam int IDX_W  = 1;

    localparam logic [WORD_W-1:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [WORD_W-1:0] BYTE_MASK = 32'h000000FF;
    localparam logic [WORD_W-1:0] CRC_RESET = 32'hFFFFFFFF;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_BITS_TO_CLEAR = 1'b0;
    localparam logic [IDX_W-1:0] REG_SEED_VALUE    = 1'b1;

    // add 2^n with wrap, then clear the low n bits
    function automatic logic [WORD_W-1:0] round_word(
        input logic [WORD_W-1:0] word,
        input logic [CLR_W-1:0]  n
    );
        logic [WORD_W-1:0] rounder;
        logic [WORD_W-1:0] mask;
        rounder = {{(WORD_W-1){1'b0}}, 1'b1} << n;
        mask    = ~(rounder - {{(WORD_W-1){1'b0}}, 1'b1});
        return (word + rounder) & mask;
    endfunction

    // one reflected byte step, bit by bit
    function automatic logic [WORD_W-1:0] crc_fold_byte(
        input logic [WORD_W-1:0] crc,
        input logic [7:0]        byte_in
    );
        logic [WORD_W-1:0] c;
        c = crc ^ ({24'd0, byte_in} & BYTE_MASK);
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hdl/rwc32_fold.sv
// ----------------------------------------------------------------------------
// rwc32_fold
// folds one 32-bit word into a reflected crc32, low byte first
// ----------------------------------------------------------------------------
module rwc32_fold (
    input  logic [rwc32_pkg::WORD_W-1:0] crc_in,
    input  logic [rwc32_pkg::WORD_W-1:0] word_in,
    output logic [rwc32_pkg::WORD_W-1:0] crc_out
);
    import rwc32_pkg::*;

    logic [WORD_W-1:0] c0;
    logic [WORD_W-1:0] c1;
    logic [WORD_W-1:0] c2;

    always_comb begin
        c0      = crc_fold_byte(crc_in, word_in[7:0]);
        c1      = crc_fold_byte(c0, word_in[15:8]);
        c2      = crc_fold_byte(c1, word_in[23:16]);
        crc_out = crc_fold_byte(c2, word_in[31:24]);
    end

endmodule

FILE: hdl/rounded_word_crc32_accumulator.sv
// ----------------------------------------------------------------------------
// rounded_word_crc32_accumulator
// streaming crc32 over coarsened float words with restart and final inversion
// ----------------------------------------------------------------------------
// Each input transfer carries one 32-bit word. The word is rounded (2^n added
// with wrap, low n bits cleared, n = bits_to_clear) as it is registered, and
// as it leaves the input register its four bytes, low byte first, are folded
// into the running reflected crc32 (polynomial 0xEDB88320). tuser set reloads
// the running value from seed_value before the word is folded in. On a
// transfer with tlast set the value is inverted, kept as the new running value
// and presented on m_tdata. One word is taken every cycle except while the
// input is held; the result is registered after the input register and the
// four-byte fold. The input keeps flowing while a result waits; only a second
// final word that would overwrite an untaken result holds the input. The user
// must write configuration through cfg_wr_en / cfg_index / cfg_wdata while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "rounded_word_crc32_accumulator_macros.svh"

module rounded_word_crc32_accumulator (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [rwc32_pkg::IDX_W-1:0]   cfg_index,
    input  logic [rwc32_pkg::WORD_W-1:0]  cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rwc32_pkg::WORD_W-1:0]  s_tdata,  // [31:0] data_word
    input  logic                          s_tuser,  // [0] restart
    input  logic                          s_tlast,  // last_word
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rwc32_pkg::WORD_W-1:0]  m_tdata   // [31:0] crc_result
);
    import rwc32_pkg::*;

    // configuration registers
    logic [CLR_W-1:0]  bits_to_clear_reg;
    logic [WORD_W-1:0] seed_value_reg;

    // input stage: rounded word plus flags
    logic              in_vld_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic              in_restart_reg;
    logic              in_last_reg;

    // running crc and result register
    logic [WORD_W-1:0] running_crc_reg;
    logic [WORD_W-1:0] running_crc_next;
    logic              m_tvalid_reg;
    logic [WORD_W-1:0] m_tdata_reg;

    logic [WORD_W-1:0] crc_start;
    logic [WORD_W-1:0] crc_folded;
    logic              advance;   // input stage item moves on this cycle
    logic              s_xfer;

    // a final word can move only when the result register is free or drains
    assign advance  = in_vld_reg && (!in_last_reg || !m_tvalid_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    // register writes; out-of-range codes cannot occur with this index width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_to_clear_reg <= '0;
            seed_value_reg    <= CRC_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BITS_TO_CLEAR: bits_to_clear_reg <= cfg_wdata[CLR_W-1:0];
                REG_SEED_VALUE:    seed_value_reg    <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // input register, rounding done on the way in
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_word_reg    <= round_word(s_tdata, bits_to_clear_reg);
            in_restart_reg <= s_tuser;
            in_last_reg    <= s_tlast;
        end
    end

    // crc update
    assign crc_start = in_restart_reg ? seed_value_reg : running_crc_reg;

    rwc32_fold u_fold (
        .crc_in  (crc_start),
        .word_in (in_word_reg),
        .crc_out (crc_folded)
    );

    assign running_crc_next = in_last_reg ? ~crc_folded : crc_folded;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_crc_reg <= CRC_RESET;
        end else if (advance) begin
            running_crc_reg <= running_crc_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            m_tdata_reg <= running_crc_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a final word leaves the result equal to the new running value
    `RWC32_ASSERT_NEXT(a_result_matches_state, advance && in_last_reg, m_tvalid_reg && (m_tdata_reg == running_crc_reg))
    // a non-final word never drops a waiting result
    `RWC32_ASSERT_NEXT(a_result_kept, advance && !in_last_reg && m_tvalid_reg && !m_tready, m_tvalid_reg)
    // input only held by a final word blocked behind an untaken result
    `RWC32_ASSERT_SAME(a_ready_reason, !s_tready, in_vld_reg && in_last_reg && m_tvalid_reg && !m_tready)
    // running value stays put while nothing moves
    `RWC32_ASSERT_NEXT(a_state_hold, !advance, $stable(running_crc_reg))

endmodule

FILE: tb/sv/tb_rounded_word_crc32_accumulator.sv
// ----------------------------------------------------------------------------
// tb_rounded_word_crc32_accumulator
// stream test of the rounded word crc32 accumulator: directed corner words,
// then random vectors under several configurations and idle/stall mixes, with
// every result checked against an in-bench crc predictor
// ----------------------------------------------------------------------------
module tb_rounded_word_crc32_accumulator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
    localparam int SETTLE_CYCLES  = 4;     // input and result registers plus margin
    localparam int PHASE_WORDS    = 300;

    // ------------------------------------------------------------------------
    // crc predictor and store of expected results
    // ------------------------------------------------------------------------
    class crc_scoreboard;
        logic [31:0] crc_state;
        logic [31:0] seed;
        logic [4:0]  clear_bits;
        logic [31:0] expected_crcs[$];
        int          errors;

        function new();
            crc_state  = 32'hFFFF_FFFF;
            seed       = 32'hFFFF_FFFF;
            clear_bits = 5'd0;
            errors     = 0;
        endfunction

        function void write_reg(logic [rwc32_pkg::IDX_W-1:0] idx, logic [31:0] value);
            if (idx == rwc32_pkg::REG_BITS_TO_CLEAR) begin
                clear_bits = value[4:0];
            end else if (idx == rwc32_pkg::REG_SEED_VALUE) begin
                seed = value;
            end
        endfunction

        // one accepted input transfer; queues a crc when the word closes a vector
        function void note_word(logic [31:0] word, bit restart, bit is_last);
            logic [31:0] step;
            logic [31:0] coarse;
            logic [31:0] c;
            step   = 32'd1 << clear_bits;
            coarse = (word + step) & ~(step - 32'd1);
            c      = restart ? seed : crc_state;
            // four lsb-first byte steps are the same as 32 bit steps on the xor
            c = c ^ coarse;
            for (int i = 0; i < 32; i++) begin
                c = c[0] ? ((c >> 1) ^ rwc32_pkg::CRC_POLY) : (c >> 1);
            end
            if (is_last) begin
                c = ~c;
                expected_crcs.push_back(c);
            end
            crc_state = c;
        endfunction

        function void check_crc(logic [31:0] actual);
            logic [31:0] want;
            if (expected_crcs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transfer, crc_result actual %08h",
                         $time, actual);
            end else begin
                want = expected_crcs.pop_front();
                if (actual !== want) begin
                    errors++;
                    $display("%0t: crc_result mismatch, expected %08h actual %08h",
                             $time, want, actual);
                end
            end
        endfunction

        function int pending();
            return expected_crcs.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block
    // ------------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [rwc32_pkg::IDX_W-1:0]  cfg_index;
    logic [rwc32_pkg::WORD_W-1:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] data_word
    logic        s_tuser;   // [0] restart
    logic        s_tlast;   // last_word
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] crc_result

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          idle_cycles    = 0;

    crc_scoreboard sb = new();

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    rounded_word_crc32_accumulator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ------------------------------------------------------------------------
    // result side: check every transfer, then pick next cycle's tready
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                sb.check_crc(m_tdata);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: any transfer on either side counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, sb.pending());
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // input side tasks
    // ------------------------------------------------------------------------

    // one input transfer, with random idle cycles ahead of it; tvalid is left
    // high so back-to-back words need no second assignment in the same step
    task automatic send_word(input logic [31:0] word, input bit restart, input bit is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= restart;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(word, restart, is_last);
    endtask

    // hold the input until every queued crc has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // registers change only once the pipeline is empty, including a word
    // that closes no vector and so leaves no result to wait for
    task automatic configure(input logic [4:0] clear_bits, input logic [31:0] seed);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= rwc32_pkg::REG_BITS_TO_CLEAR;
        cfg_wdata <= {27'd0, clear_bits};
        @(posedge aclk);
        sb.write_reg(rwc32_pkg::REG_BITS_TO_CLEAR, {27'd0, clear_bits});
        cfg_index <= rwc32_pkg::REG_SEED_VALUE;
        cfg_wdata <= seed;
        @(posedge aclk);
        sb.write_reg(rwc32_pkg::REG_SEED_VALUE, seed);
        cfg_wr_en <= 1'b0;
    endtask

    // word mix biased toward carries through the rounding add
    function automatic logic [31:0] pick_word();
        int unsigned sel;
        sel = $urandom_range(9);
        case (sel)
            0: begin
                return 32'hFFFF_FFFF - $urandom_range(15);
            end
            1: begin
                return $urandom_range(15);
            end
            2, 3: begin
                // low run of ones so the rounder carries a long way
                return $urandom | ((32'd1 << $urandom_range(31)) - 32'd1);
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    // well-formed vectors with random content; a few restart mid-vector or
    // skip the restart and run on from the previous inverted crc
    task automatic run_vectors(input int n_words);
        int sent;
        int len;
        sent = 0;
        while (sent < n_words) begin
            len = ($urandom_range(9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 16);
            for (int i = 0; i < len; i++) begin
                send_word(pick_word(),
                          (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0),
                          i == len - 1);
                sent++;
            end
        end
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input logic [4:0] clear_bits, input logic [31:0] seed);
        configure(clear_bits, seed);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        run_vectors(PHASE_WORDS / 2);
        // sender holds off until all results are out, then resumes
        drain();
        run_vectors(PHASE_WORDS / 2);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= rwc32_pkg::REG_BITS_TO_CLEAR;
        cfg_wdata <= 32'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 32'd0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: nothing cleared, all-ones seed
        send_word(32'h0000_0000, 1'b1, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1, 1'b1);   // plus one wraps to zero
        send_word(32'h7FFF_FFFF, 1'b0, 1'b1);   // runs on from the inverted crc
        send_word(32'h3F80_0000, 1'b1, 1'b0);
        send_word(32'h5555_5555, 1'b0, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b1, 1'b0);   // restart inside a vector
        send_word(32'h0000_0001, 1'b0, 1'b1);

        // clear 31 bits: only the top bit survives, add wraps
        configure(5'd31, 32'h0000_0000);
        send_word(32'h7FFF_FFFF, 1'b1, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_word(32'h8000_0000, 1'b1, 1'b0);
        send_word(32'h1234_5678, 1'b0, 1'b1);

        configure(5'd1, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFE, 1'b1, 1'b1);
        send_word(32'h0000_0001, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b1);

        // random part under several register settings and idle/stall mixes
        run_phase(0,  0,  5'($urandom_range(31)), $urandom);
        run_phase(47, 0,  5'd31, 32'h0000_0000);
        run_phase(0,  47, 5'd0,  32'hFFFF_FFFF);
        run_phase(9,  9,  5'($urandom_range(1, 30)), $urandom);

        drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/rwc32_pkg.sv
hdl/rwc32_fold.sv
hdl/rounded_word_crc32_accumulator.sv
tb/sv/tb_rounded_word_crc32_accumulator.sv
